FILE: rtl/grrts_pkg.sv
// Shared types, codes and helpers for the group round-robin task scheduler.
`timescale 1ns / 1ps
package grrts_pkg;

	localparam int unsigned TASK_SLOTS_DEF  = 256;
	localparam int unsigned GROUP_COUNT_DEF = 64;

	localparam logic [1:0] OPC_SUBMIT = 2'd0;
	localparam logic [1:0] OPC_SELECT = 2'd1;
	localparam logic [1:0] OPC_FINISH = 2'd2;
	localparam logic [1:0] OPC_NOP    = 2'd3;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_NONE   = 2'd1;
	localparam logic [1:0] ST_EXISTS = 2'd2;
	localparam logic [1:0] ST_FULL   = 2'd3;

	typedef enum logic [1:0] {
		OP_SUBMIT,
		OP_SELECT,
		OP_FINISH,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [31:0] id;
		logic [5:0]  grp;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] chosen;
	} res_t;

	typedef enum logic [3:0] {
		S_CLR,
		S_IDLE,
		S_SCAN,
		S_SUB,
		S_SEL0,
		S_SEL1,
		S_SEL2,
		S_FIN0,
		S_FIN1,
		S_DONE
	} state_t;

	// group index modulo gc by restoring subtraction, six narrow steps
	function automatic logic [5:0] grp_wrap(input logic [5:0] g, input int unsigned gc);
		logic [31:0] r;
		logic [31:0] d;
		r = 32'(g);
		for (int k = 5; k >= 0; k--) begin
			d = 32'(gc) << k;
			if (r >= d) begin
				r = r - d;
			end
		end
		return r[5:0];
	endfunction

endpackage

FILE: rtl/group_round_robin_task_scheduler_top.sv
// From input beat to result beat, submit and finish are paced by the id search reading the
// slot memory one entry a cycle; select and nop do not scan.
// One command in the engine at a time; two wait in front, two results at the back.
// After reset a clearing pass runs over the slot and queue memories with full held high.
// Reset is asynchronous, active low; all queues come up empty and the ring empty.
`timescale 1ns / 1ps
module group_round_robin_task_scheduler_top #(
	parameter int unsigned TASK_SLOTS  = grrts_pkg::TASK_SLOTS_DEF,
	parameter int unsigned GROUP_COUNT = grrts_pkg::GROUP_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  opcode,
	input  logic [31:0] task_id,
	input  logic [5:0]  group_id,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  status,
	output logic [31:0] chosen_task_id
);

	logic            cmd_valid;
	logic            cmd_ready;
	grrts_pkg::cmd_t cmd;
	logic            busy_clr;
	logic            res_valid;
	logic            res_ready;
	grrts_pkg::res_t res;

	grrts_front #(.GROUP_COUNT(GROUP_COUNT)) u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.opcode(opcode), .task_id(task_id), .group_id(group_id),
		.hold(busy_clr), .cmd_valid(cmd_valid), .cmd(cmd), .cmd_ready(cmd_ready)
	);

	grrts_engine #(.TASK_SLOTS(TASK_SLOTS), .GROUP_COUNT(GROUP_COUNT)) u_engine (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd(cmd),
		.cmd_ready(cmd_ready), .busy_clr(busy_clr), .res_valid(res_valid),
		.res(res), .res_ready(res_ready)
	);

	grrts_res_q u_res_q (
		.clk(clk), .arst_n(arst_n), .res_valid(res_valid), .res(res),
		.res_ready(res_ready), .empty(empty), .pop(pop), .status(status),
		.chosen_task_id(chosen_task_id)
	);

endmodule

FILE: rtl/grrts_ram.sv
// Generic single write port, single read port RAM with registered read.
`timescale 1ns / 1ps
module grrts_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/grrts_front.sv
// Front end: decodes and wraps incoming commands into a two-entry queue.
`timescale 1ns / 1ps
module grrts_front #(
	parameter int unsigned GROUP_COUNT = grrts_pkg::GROUP_COUNT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [1:0]        opcode,
	input  logic [31:0]       task_id,
	input  logic [5:0]        group_id,
	input  logic              hold,
	output logic              cmd_valid,
	output grrts_pkg::cmd_t   cmd,
	input  logic              cmd_ready
);

	grrts_pkg::cmd_t ent_q [2];
	logic            wr_q;
	logic            rd_q;
	logic [1:0]      cnt_q;
	grrts_pkg::cmd_t cls;
	logic            wr_en;
	logic            rd_en;

	always_comb begin
		case (opcode)
			grrts_pkg::OPC_SUBMIT: cls.op = grrts_pkg::OP_SUBMIT;
			grrts_pkg::OPC_SELECT: cls.op = grrts_pkg::OP_SELECT;
			grrts_pkg::OPC_FINISH: cls.op = grrts_pkg::OP_FINISH;
			default:               cls.op = grrts_pkg::OP_NOP;
		endcase
		cls.id  = task_id;
		cls.grp = grrts_pkg::grp_wrap(group_id, GROUP_COUNT);
	end

	assign full      = hold || (cnt_q == 2'd2);
	assign wr_en     = push && !full;
	assign cmd_valid = (cnt_q != 2'd0);
	assign rd_en     = cmd_valid && cmd_ready;
	assign cmd       = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ent_q[wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_q <= ~wr_q;
			end
			if (rd_en) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(wr_en) - 2'(rd_en);
		end
	end

endmodule

FILE: rtl/grrts_engine.sv
// Back end: sequencer over the slot, queue and ring memories.
`timescale 1ns / 1ps
module grrts_engine #(
	parameter int unsigned TASK_SLOTS  = grrts_pkg::TASK_SLOTS_DEF,
	parameter int unsigned GROUP_COUNT = grrts_pkg::GROUP_COUNT_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	input  grrts_pkg::cmd_t cmd,
	output logic            cmd_ready,
	output logic            busy_clr,
	output logic            res_valid,
	output grrts_pkg::res_t res,
	input  logic            res_ready
);

	localparam int unsigned SW   = $clog2(TASK_SLOTS);
	localparam int unsigned CW   = $clog2(TASK_SLOTS + 1);
	localparam int unsigned GW   = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
	localparam int unsigned CLRN = (TASK_SLOTS > GROUP_COUNT) ? TASK_SLOTS : GROUP_COUNT;
	localparam int unsigned CLRW = $clog2(CLRN + 1);
	localparam int unsigned SRW  = 1 + GW + 32;
	localparam int unsigned QRW  = SW + SW + CW;

	grrts_pkg::state_t state_q, state_d;

	logic [31:0]     id_q;
	grrts_pkg::op_t  op_q;
	logic [GW-1:0]   grp_q;
	logic [SW-1:0]   slot_q;
	logic [CLRW-1:0] clr_q;
	logic [SW:0]     scan_q;
	logic            rd_vld_q;
	logic            hit_q;
	logic [SW-1:0]   hit_idx_q;
	logic [GW-1:0]   hit_grp_q;
	logic            free_vld_q;
	logic [SW-1:0]   free_idx_q;
	logic [SW-1:0]   rd_idx_q;
	logic [GW-1:0]   ring_head_q, ring_head_d;
	logic [GW-1:0]   ring_tail_q, ring_tail_d;
	logic            ring_empty_q, ring_empty_d;
	grrts_pkg::res_t res_q, res_d;

	logic           sr_we;
	logic [SW-1:0]  sr_waddr, sr_raddr;
	logic [SRW-1:0] sr_wdata, sr_rdata;
	logic           qr_we;
	logic [QRW-1:0] qr_wdata, qr_rdata;
	logic [GW-1:0]  qr_waddr;
	logic           nx_we, pv_we;
	logic [SW-1:0]  nx_waddr, nx_wdata, nx_raddr, nx_rdata;
	logic [SW-1:0]  pv_waddr, pv_wdata, pv_rdata;
	logic           rn_we, rp_we;
	logic [GW-1:0]  rn_waddr, rn_wdata, rn_rdata;
	logic [GW-1:0]  rp_waddr, rp_wdata, rp_rdata;

	logic          sr_used;
	logic [GW-1:0] sr_grp;
	logic [31:0]   sr_task;
	logic [SW-1:0] q_head, q_tail, new_head, new_tail;
	logic [CW-1:0] q_cnt, new_cnt;
	logic          scan_end;
	logic          accept;

	assign sr_used = sr_rdata[SRW-1];
	assign sr_grp  = sr_rdata[32 +: GW];
	assign sr_task = sr_rdata[31:0];
	assign q_head  = qr_rdata[CW+SW +: SW];
	assign q_tail  = qr_rdata[CW +: SW];
	assign q_cnt   = qr_rdata[CW-1:0];

	assign cmd_ready = (state_q == grrts_pkg::S_IDLE);
	assign accept    = cmd_valid && cmd_ready;
	assign busy_clr  = (state_q == grrts_pkg::S_CLR);
	assign res_valid = (state_q == grrts_pkg::S_DONE);
	assign res       = res_q;
	assign scan_end  = (scan_q == (SW+1)'(TASK_SLOTS)) && !rd_vld_q;

	always_comb begin
		case (state_q)
			grrts_pkg::S_SCAN: sr_raddr = scan_q[SW-1:0];
			grrts_pkg::S_SEL1: sr_raddr = q_head;
			default:           sr_raddr = slot_q;
		endcase
		nx_raddr = (state_q == grrts_pkg::S_SEL1) ? q_head : slot_q;
	end

	grrts_ram #(.WIDTH(SRW), .DEPTH(TASK_SLOTS)) u_slot (
		.clk(clk), .we(sr_we), .waddr(sr_waddr), .wdata(sr_wdata),
		.raddr(sr_raddr), .rdata(sr_rdata)
	);
	grrts_ram #(.WIDTH(SW), .DEPTH(TASK_SLOTS)) u_next (
		.clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
		.raddr(nx_raddr), .rdata(nx_rdata)
	);
	grrts_ram #(.WIDTH(SW), .DEPTH(TASK_SLOTS)) u_prev (
		.clk(clk), .we(pv_we), .waddr(pv_waddr), .wdata(pv_wdata),
		.raddr(slot_q), .rdata(pv_rdata)
	);
	grrts_ram #(.WIDTH(QRW), .DEPTH(GROUP_COUNT)) u_queue (
		.clk(clk), .we(qr_we), .waddr(qr_waddr), .wdata(qr_wdata),
		.raddr(grp_q), .rdata(qr_rdata)
	);
	grrts_ram #(.WIDTH(GW), .DEPTH(GROUP_COUNT)) u_rnext (
		.clk(clk), .we(rn_we), .waddr(rn_waddr), .wdata(rn_wdata),
		.raddr(grp_q), .rdata(rn_rdata)
	);
	grrts_ram #(.WIDTH(GW), .DEPTH(GROUP_COUNT)) u_rprev (
		.clk(clk), .we(rp_we), .waddr(rp_waddr), .wdata(rp_wdata),
		.raddr(grp_q), .rdata(rp_rdata)
	);

	always_comb begin
		state_d      = state_q;
		res_d        = res_q;
		ring_head_d  = ring_head_q;
		ring_tail_d  = ring_tail_q;
		ring_empty_d = ring_empty_q;
		sr_we = 1'b0; sr_waddr = slot_q; sr_wdata = '0;
		qr_we = 1'b0; qr_waddr = grp_q;  qr_wdata = '0;
		nx_we = 1'b0; nx_waddr = '0; nx_wdata = '0;
		pv_we = 1'b0; pv_waddr = '0; pv_wdata = '0;
		rn_we = 1'b0; rn_waddr = '0; rn_wdata = '0;
		rp_we = 1'b0; rp_waddr = '0; rp_wdata = '0;
		new_head = q_head;
		new_tail = q_tail;
		new_cnt  = q_cnt;

		case (state_q)
			grrts_pkg::S_CLR: begin
				if (clr_q < CLRW'(TASK_SLOTS)) begin
					sr_we    = 1'b1;
					sr_waddr = clr_q[SW-1:0];
				end
				if (clr_q < CLRW'(GROUP_COUNT)) begin
					qr_we    = 1'b1;
					qr_waddr = GW'(clr_q);
				end
				if (clr_q == CLRW'(CLRN - 1)) begin
					state_d = grrts_pkg::S_IDLE;
				end
			end
			grrts_pkg::S_IDLE: begin
				if (cmd_valid) begin
					case (cmd.op)
						grrts_pkg::OP_SUBMIT, grrts_pkg::OP_FINISH: state_d = grrts_pkg::S_SCAN;
						grrts_pkg::OP_SELECT: begin
							if (ring_empty_q) begin
								res_d   = '{status: grrts_pkg::ST_NONE, chosen: 32'd0};
								state_d = grrts_pkg::S_DONE;
							end else begin
								state_d = grrts_pkg::S_SEL0;
							end
						end
						default: begin
							res_d   = '{status: grrts_pkg::ST_OK, chosen: 32'd0};
							state_d = grrts_pkg::S_DONE;
						end
					endcase
				end
			end
			grrts_pkg::S_SCAN: begin
				if (scan_end) begin
					res_d   = '{status: grrts_pkg::ST_OK, chosen: 32'd0};
					state_d = grrts_pkg::S_DONE;
					if (op_q == grrts_pkg::OP_SUBMIT) begin
						if (hit_q) begin
							res_d.status = grrts_pkg::ST_EXISTS;
						end else if (!free_vld_q) begin
							res_d.status = grrts_pkg::ST_FULL;
						end else begin
							state_d = grrts_pkg::S_SUB;
						end
					end else if (hit_q) begin
						state_d = grrts_pkg::S_FIN0;
					end
				end
			end
			grrts_pkg::S_SUB: begin
				sr_we    = 1'b1;
				sr_wdata = {1'b1, grp_q, id_q};
				qr_we    = 1'b1;
				if (q_cnt == '0) begin
					qr_wdata = {slot_q, slot_q, CW'(1)};
					if (ring_empty_q) begin
						ring_head_d  = grp_q;
						ring_tail_d  = grp_q;
						ring_empty_d = 1'b0;
					end else begin
						rn_we = 1'b1; rn_waddr = ring_tail_q; rn_wdata = grp_q;
						rp_we = 1'b1; rp_waddr = grp_q; rp_wdata = ring_tail_q;
						ring_tail_d = grp_q;
					end
				end else begin
					nx_we = 1'b1; nx_waddr = q_tail; nx_wdata = slot_q;
					pv_we = 1'b1; pv_waddr = slot_q; pv_wdata = q_tail;
					qr_wdata = {q_head, slot_q, CW'(q_cnt + 1'b1)};
				end
				state_d = grrts_pkg::S_DONE;
			end
			grrts_pkg::S_SEL0: state_d = grrts_pkg::S_SEL1;
			grrts_pkg::S_SEL1: begin
				// the selected group is always the ring head
				if (ring_head_q == ring_tail_q) begin
					ring_empty_d = 1'b1;
				end else begin
					ring_head_d = rn_rdata;
				end
				if (q_cnt == '0) begin
					res_d   = '{status: grrts_pkg::ST_NONE, chosen: 32'd0};
					state_d = grrts_pkg::S_DONE;
				end else begin
					state_d = grrts_pkg::S_SEL2;
				end
			end
			grrts_pkg::S_SEL2: begin
				res_d    = '{status: grrts_pkg::ST_OK, chosen: sr_task};
				sr_we    = 1'b1;
				sr_wdata = {1'b0, sr_grp, sr_task};
				new_cnt  = CW'(q_cnt - 1'b1);
				if (q_cnt > CW'(1)) begin
					new_head = nx_rdata;
				end
				qr_we    = 1'b1;
				qr_wdata = {new_head, q_tail, new_cnt};
				if (new_cnt != '0) begin
					if (ring_empty_q) begin
						ring_head_d  = grp_q;
						ring_tail_d  = grp_q;
						ring_empty_d = 1'b0;
					end else begin
						rn_we = 1'b1; rn_waddr = ring_tail_q; rn_wdata = grp_q;
						rp_we = 1'b1; rp_waddr = grp_q; rp_wdata = ring_tail_q;
						ring_tail_d = grp_q;
					end
				end
				state_d = grrts_pkg::S_DONE;
			end
			grrts_pkg::S_FIN0: state_d = grrts_pkg::S_FIN1;
			grrts_pkg::S_FIN1: begin
				res_d    = '{status: grrts_pkg::ST_OK, chosen: 32'd0};
				sr_we    = 1'b1;
				sr_wdata = {1'b0, grp_q, id_q};
				if (q_cnt > CW'(1)) begin
					if (slot_q == q_head) begin
						new_head = nx_rdata;
					end else if (slot_q == q_tail) begin
						new_tail = pv_rdata;
					end else begin
						nx_we = 1'b1; nx_waddr = pv_rdata; nx_wdata = nx_rdata;
						pv_we = 1'b1; pv_waddr = nx_rdata; pv_wdata = pv_rdata;
					end
				end
				if (q_cnt != '0) begin
					new_cnt = CW'(q_cnt - 1'b1);
				end
				qr_we    = 1'b1;
				qr_wdata = {new_head, new_tail, new_cnt};
				if (new_cnt == '0 && !ring_empty_q) begin
					if (ring_head_q == ring_tail_q) begin
						ring_empty_d = 1'b1;
					end else if (grp_q == ring_head_q) begin
						ring_head_d = rn_rdata;
					end else if (grp_q == ring_tail_q) begin
						ring_tail_d = rp_rdata;
					end else begin
						rn_we = 1'b1; rn_waddr = rp_rdata; rn_wdata = rn_rdata;
						rp_we = 1'b1; rp_waddr = rn_rdata; rp_wdata = rp_rdata;
					end
				end
				state_d = grrts_pkg::S_DONE;
			end
			grrts_pkg::S_DONE: begin
				if (res_ready) begin
					state_d = grrts_pkg::S_IDLE;
				end
			end
			default: state_d = grrts_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= grrts_pkg::S_CLR;
			clr_q        <= '0;
			ring_head_q  <= '0;
			ring_tail_q  <= '0;
			ring_empty_q <= 1'b1;
			rd_vld_q     <= 1'b0;
		end else begin
			state_q      <= state_d;
			ring_head_q  <= ring_head_d;
			ring_tail_q  <= ring_tail_d;
			ring_empty_q <= ring_empty_d;
			rd_vld_q     <= (state_q == grrts_pkg::S_SCAN) && (scan_q < (SW+1)'(TASK_SLOTS));
			if (state_q == grrts_pkg::S_CLR) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		res_q    <= res_d;
		rd_idx_q <= scan_q[SW-1:0];
		if (accept) begin
			id_q       <= cmd.id;
			op_q       <= cmd.op;
			grp_q      <= (cmd.op == grrts_pkg::OP_SELECT) ? ring_head_q : GW'(cmd.grp);
			scan_q     <= '0;
			hit_q      <= 1'b0;
			free_vld_q <= 1'b0;
		end
		if (state_q == grrts_pkg::S_SCAN) begin
			if (scan_q < (SW+1)'(TASK_SLOTS)) begin
				scan_q <= scan_q + 1'b1;
			end
			if (rd_vld_q) begin
				if (sr_used && sr_task == id_q && !hit_q) begin
					hit_q     <= 1'b1;
					hit_idx_q <= rd_idx_q;
					hit_grp_q <= sr_grp;
				end
				if (!sr_used && !free_vld_q) begin
					free_vld_q <= 1'b1;
					free_idx_q <= rd_idx_q;
				end
			end
			if (scan_end) begin
				slot_q <= (op_q == grrts_pkg::OP_SUBMIT) ? free_idx_q : hit_idx_q;
				if (op_q == grrts_pkg::OP_FINISH) begin
					grp_q <= hit_grp_q;
				end
			end
		end
		if (state_q == grrts_pkg::S_SEL1) begin
			slot_q <= q_head;
		end
	end

endmodule

FILE: rtl/grrts_res_q.sv
// Two-entry result queue presented as the output side of the block.
`timescale 1ns / 1ps
module grrts_res_q (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            res_valid,
	input  grrts_pkg::res_t res,
	output logic            res_ready,
	output logic            empty,
	input  logic            pop,
	output logic [1:0]      status,
	output logic [31:0]     chosen_task_id
);

	grrts_pkg::res_t ent_q [2];
	logic            wr_q;
	logic            rd_q;
	logic [1:0]      cnt_q;
	logic            wr_en;
	logic            rd_en;

	assign res_ready      = (cnt_q != 2'd2);
	assign wr_en          = res_valid && res_ready;
	assign empty          = (cnt_q == 2'd0);
	assign rd_en          = pop && !empty;
	assign status         = ent_q[rd_q].status;
	assign chosen_task_id = ent_q[rd_q].chosen;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ent_q[wr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_q <= ~wr_q;
			end
			if (rd_en) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(wr_en) - 2'(rd_en);
		end
	end

endmodule

FILE: rtl/grrts_checker.sv
// Port-level checker for the scheduler, bound to the top level.
`timescale 1ns / 1ps
module grrts_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        push,
	input logic        full,
	input logic        empty,
	input logic        pop,
	input logic [1:0]  status,
	input logic [31:0] chosen_task_id
);

	logic [3:0] outst_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outst_q <= '0;
		end else begin
			outst_q <= outst_q + 4'(push && !full) - 4'(pop && !empty);
		end
	end

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		outst_q == 4'd0 |-> empty)
		else $error("result beat with no command outstanding");

	a_zero_id: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && status != grrts_pkg::ST_OK |-> chosen_task_id == 32'd0)
		else $error("nonzero task id on failed result");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty)
		else $error("result dropped without pop");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> $stable(status) && $stable(chosen_task_id))
		else $error("stalled result changed");

endmodule

bind group_round_robin_task_scheduler_top grrts_checker u_chk (.*);

FILE: tb/group_round_robin_task_scheduler_top_tb.sv
// Self-checking bench for the group round-robin task scheduler: queue-style driver, monitor, predictor.
`timescale 1ns / 1ps
module group_round_robin_task_scheduler_top_tb;

	localparam int unsigned SLOTS  = 256;
	localparam int unsigned GROUPS = 64;

	typedef struct {
		logic [1:0]  op;
		logic [31:0] id;
		logic [5:0]  grp;
	} sched_cmd_t;

	typedef struct {
		logic [1:0]  status;
		logic [31:0] chosen;
	} sched_res_t;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [1:0]  opcode;
	logic [31:0] task_id;
	logic [5:0]  group_id;
	logic        empty;
	logic        pop;
	logic [1:0]  status;
	logic [31:0] chosen_task_id;

	group_round_robin_task_scheduler_top dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.opcode(opcode), .task_id(task_id), .group_id(group_id),
		.empty(empty), .pop(pop), .status(status), .chosen_task_id(chosen_task_id)
	);

	// predictor state: per-group FIFOs of slot numbers and a ring of groups
	logic        pr_used [SLOTS];
	logic [31:0] pr_task [SLOTS];
	logic [5:0]  pr_group [SLOTS];
	int          grp_fifo [GROUPS][$];
	int          grp_ring [$];

	sched_cmd_t  cmd_q [$];
	sched_res_t  expected_q [$];
	logic [31:0] live_ids [$];
	int          errors;
	int          sent;
	int          got;
	int          n_sub, n_sel, n_fin, n_full, n_dup, n_none;
	bit          quiet;
	bit          hold_off;
	logic        full_s;
	int          drv_gap;
	int          rcv_gap;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic int find_slot(logic [31:0] id);
		for (int s = 0; s < SLOTS; s++)
			if (pr_used[s] && pr_task[s] == id)
				return s;
		return -1;
	endfunction

	function automatic void drop_from_ring(int g);
		foreach (grp_ring[i])
			if (grp_ring[i] == g) begin
				grp_ring.delete(i);
				return;
			end
	endfunction

	function automatic sched_res_t schedule_step(sched_cmd_t c);
		sched_res_t r;
		int s, g;
		r.status = grrts_pkg::ST_OK;
		r.chosen = '0;
		case (c.op)
			grrts_pkg::OPC_SUBMIT: begin
				if (find_slot(c.id) >= 0) begin
					r.status = grrts_pkg::ST_EXISTS;
				end else begin
					s = -1;
					for (int k = 0; k < SLOTS; k++)
						if (!pr_used[k]) begin
							s = k;
							break;
						end
					if (s < 0) begin
						r.status = grrts_pkg::ST_FULL;
					end else begin
						g = c.grp % GROUPS;
						pr_used[s] = 1'b1;
						pr_task[s] = c.id;
						pr_group[s] = 6'(g);
						if (grp_fifo[g].size() == 0)
							grp_ring.push_back(g);
						grp_fifo[g].push_back(s);
					end
				end
			end
			grrts_pkg::OPC_SELECT: begin
				if (grp_ring.size() == 0) begin
					r.status = grrts_pkg::ST_NONE;
				end else begin
					g = grp_ring.pop_front();
					s = grp_fifo[g].pop_front();
					r.chosen = pr_task[s];
					pr_used[s] = 1'b0;
					if (grp_fifo[g].size() != 0)
						grp_ring.push_back(g);
				end
			end
			grrts_pkg::OPC_FINISH: begin
				s = find_slot(c.id);
				if (s >= 0) begin
					g = pr_group[s];
					for (int i = 0; i < grp_fifo[g].size(); i++)
						if (grp_fifo[g][i] == s) begin
							grp_fifo[g].delete(i);
							break;
						end
					pr_used[s] = 1'b0;
					if (grp_fifo[g].size() == 0)
						drop_from_ring(g);
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] pick_id();
		if (live_ids.size() != 0 && $urandom_range(0, 2) != 0)
			return live_ids[$urandom_range(0, live_ids.size() - 1)];
		return $urandom_range(0, 3) == 0 ? 32'($urandom_range(0, 15)) : $urandom;
	endfunction

	function automatic void add_cmd(logic [1:0] op, logic [31:0] id, logic [5:0] grp);
		sched_cmd_t c;
		c.op = op;
		c.id = id;
		c.grp = grp;
		cmd_q.push_back(c);
		if (op == grrts_pkg::OPC_SUBMIT && live_ids.size() < 400)
			live_ids.push_back(id);
	endfunction

	// sampled at the rising edge so the driver sees what the block saw
	always @(posedge clk) full_s <= full;

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (push && !full_s) begin
				cmd_q.pop_front();
				sent++;
			end
			if (drv_gap > 0) begin
				drv_gap--;
				push <= 1'b0;
			end else if (!quiet && cmd_q.size() != 0 && $urandom_range(0, 7) == 0) begin
				drv_gap = $urandom_range(1, 6) - 1;
				push <= 1'b0;
			end else if (cmd_q.size() != 0) begin
				push <= 1'b1;
				opcode <= cmd_q[0].op;
				task_id <= cmd_q[0].id;
				group_id <= cmd_q[0].grp;
			end else begin
				push <= 1'b0;
			end
		end
	end

	// one long receiver hold-off once traffic is flowing, so the block backs up
	initial begin
		hold_off = 1'b0;
		wait (sent >= 40);
		@(posedge clk);
		hold_off = 1'b1;
		repeat (3000) @(posedge clk);
		hold_off = 1'b0;
	end

	// receiver side: stall bursts, plus the long hold-off
	always @(negedge clk) begin
		if (hold_off) begin
			pop <= 1'b0;
		end else if (rcv_gap > 0) begin
			rcv_gap--;
			pop <= 1'b0;
		end else if (!quiet && $urandom_range(0, 6) == 0) begin
			rcv_gap = $urandom_range(1, 6) - 1;
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
		end
	end

	// monitor
	always @(posedge clk) begin
		sched_res_t e;
		sched_cmd_t c;
		if (arst_n) begin
			if (push && !full) begin
				c = cmd_q[0];
				expected_q.push_back(schedule_step(c));
			end
			if (pop && !empty) begin
				got++;
				if (expected_q.size() == 0) begin
					$error("result beat with nothing expected");
					errors++;
				end else begin
					e = expected_q.pop_front();
					if (status !== e.status) begin
						$error("status expected %0d actual %0d", e.status, status);
						errors++;
					end
					if (chosen_task_id !== e.chosen) begin
						$error("chosen_task_id expected %h actual %h", e.chosen,
							chosen_task_id);
						errors++;
					end
					case (e.status)
						grrts_pkg::ST_FULL: n_full++;
						grrts_pkg::ST_EXISTS: n_dup++;
						grrts_pkg::ST_NONE: n_none++;
						default: ;
					endcase
				end
			end
		end
	end

	initial begin
		#200ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		int g;
		push = 1'b0;
		pop = 1'b0;
		opcode = grrts_pkg::OPC_SUBMIT;
		task_id = '0;
		group_id = '0;
		arst_n = 1'b0;
		errors = 0;
		sent = 0;
		got = 0;
		quiet = 1'b0;
		drv_gap = 0;
		rcv_gap = 0;
		for (int s = 0; s < SLOTS; s++) pr_used[s] = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// directed: empty select, extremes, duplicate, wrap, unknown finish, nop
		add_cmd(grrts_pkg::OPC_SELECT, '0, '0);
		add_cmd(grrts_pkg::OPC_SUBMIT, 32'hFFFF_FFFF, 6'd63);
		add_cmd(grrts_pkg::OPC_SUBMIT, 32'h0, 6'd0);
		add_cmd(grrts_pkg::OPC_SUBMIT, 32'h0, 6'd5);
		add_cmd(grrts_pkg::OPC_SUBMIT, 32'h5555_AAAA, 6'd63);
		add_cmd(grrts_pkg::OPC_SUBMIT, 32'hAAAA_5555, 6'd42);
		add_cmd(grrts_pkg::OPC_FINISH, 32'h1234_5678, 6'd0);
		add_cmd(grrts_pkg::OPC_NOP, 32'hFFFF_FFFF, 6'd63);
		add_cmd(grrts_pkg::OPC_SELECT, 32'hFFFF_FFFF, 6'd63);
		add_cmd(grrts_pkg::OPC_FINISH, 32'hAAAA_5555, 6'd21);
		add_cmd(grrts_pkg::OPC_SELECT, '0, '0);
		add_cmd(grrts_pkg::OPC_SELECT, '0, '0);
		add_cmd(grrts_pkg::OPC_SELECT, '0, '0);
		add_cmd(grrts_pkg::OPC_SELECT, '0, '0);
		live_ids.delete();

		// random mix
		for (int i = 0; i < 200; i++) begin
			g = $urandom_range(0, 9);
			if (g < 5) begin
				add_cmd(grrts_pkg::OPC_SUBMIT, pick_id(),
					$urandom_range(0, 3) == 0 ? 6'($urandom) : 6'($urandom_range(0, 5)));
				n_sub++;
			end else if (g < 8) begin
				add_cmd(grrts_pkg::OPC_SELECT, $urandom, 6'($urandom));
				n_sel++;
			end else if (g < 9) begin
				add_cmd(grrts_pkg::OPC_FINISH, pick_id(), 6'($urandom));
				n_fin++;
			end else begin
				add_cmd(2'($urandom), pick_id(), 6'($urandom));
			end
		end

		// fill the store to reach the full status, then take a few back out
		for (int i = 0; i < SLOTS + 3; i++)
			add_cmd(grrts_pkg::OPC_SUBMIT, 32'hC000_0000 + i, 6'(i));
		for (int i = 0; i < 30; i++)
			add_cmd(grrts_pkg::OPC_SELECT, '0, '0);

		// last part of the run goes without idle cycles
		wait (sent >= 400);
		quiet = 1'b1;

		wait (cmd_q.size() == 0 && !push);
		wait (expected_q.size() == 0);
		repeat (SLOTS + 20) @(posedge clk);
		$display("covered %0d beats: %0d submit, %0d select, %0d finish in random part",
			got, n_sub, n_sel, n_fin);
		$display("store full %0d, duplicate id %0d, nothing ready %0d", n_full, n_dup, n_none);
		if (errors == 0 && expected_q.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
